// ----- rtl/hdb_pkg.sv -----
// ----------------------------------------------------------------------------
// hdb_pkg
// Shared types and constants for the hierarchical dirty bitmap.
// ----------------------------------------------------------------------------
package hdb_pkg;

  // Fixed field widths of the request, result and capacity ports
  localparam int IDX_W      = 12;
  localparam int CAP_W      = 13;
  // Leaf summary bits examined per scan cycle
  localparam int CHUNK_BITS = 64;

  // Request codes
  typedef enum logic [1:0] {
    REQ_SET   = 2'd0,
    REQ_POP   = 2'd1,
    REQ_CLEAR = 2'd2
  } req_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SET_RD,
    ST_SET_WR,
    ST_SCAN,
    ST_POP_WR
  } state_t;

endpackage

// ----- rtl/hdb_ram.sv -----
// ----------------------------------------------------------------------------
// hdb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module hdb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/hierarchical_dirty_bitmap.sv -----
// ----------------------------------------------------------------------------
// hierarchical_dirty_bitmap
// Two-level dirty-item tracker with lowest-index pop.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken when start is high and busy is low. in_req_type selects
//   set (mark in_item_index dirty), pop (take the lowest dirty index) or
//   clear. Every request yields one result, shown for one cycle with
//   out_valid; the receiver cannot stall and must take it then.
//   Leaf words live in a RAM with a registered read port; a flop vector
//   with one bit per leaf marks the non-empty leaves and is the summary level.
//   Busy states per request:
//     set in range: ST_DIV, then ST_SET_RD; a leaf that already holds dirty
//       bits also takes ST_SET_WR (read, modify and write of that leaf)
//     pop: ST_SCAN over the 64-bit summary chunks up to the first non-empty
//       leaf, then ST_POP_WR; a pop on an empty store scans every chunk and
//       ends there, without ST_POP_WR
//     clear, out-of-range set, unknown code: none, the next request can follow
//   The result appears the cycle after the last busy cycle. Capacity is
//   written on the cfg channel (always ready) by the user only while the
//   block is idle; the block does not enforce this. Reset clears the summary
//   vector, which empties the store at once, and loads capacity with 4096.
// ----------------------------------------------------------------------------
module hierarchical_dirty_bitmap #(
  parameter int MAX_ITEMS = 4096,
  parameter int WORD_BITS = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_req_type,
  input  logic [hdb_pkg::IDX_W-1:0] in_item_index,
  output logic                     out_valid,
  output logic [hdb_pkg::IDX_W-1:0] out_found_index,
  output logic                     out_found,
  output logic                     out_range_error,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [hdb_pkg::CAP_W-1:0] cfg_capacity
);

  localparam int IDX_W      = hdb_pkg::IDX_W;
  localparam int CAP_W      = hdb_pkg::CAP_W;
  localparam int CB         = hdb_pkg::CHUNK_BITS;
  localparam int LEAF_COUNT = (MAX_ITEMS + WORD_BITS - 1) / WORD_BITS;
  localparam int LW         = (LEAF_COUNT > 1) ? $clog2(LEAF_COUNT) : 1;
  localparam int BW         = $clog2(WORD_BITS);
  localparam int CHUNKS     = (LEAF_COUNT + CB - 1) / CB;
  localparam int CHW        = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int PAD        = CHUNKS * CB;
  localparam int PEW        = $clog2(CB);
  // Exact divide by WORD_BITS for 12-bit indices: q = (idx * RECIP) >> DIV_SHIFT
  localparam int DIV_SHIFT  = IDX_W + BW;
  localparam int RECIP      = ((1 << DIV_SHIFT) + WORD_BITS - 1) / WORD_BITS;
  localparam int PW         = IDX_W + CAP_W + 1;
  localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(MAX_ITEMS);
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(4096);

  hdb_pkg::state_t state_r, state_nxt;

  logic [CAP_W-1:0]     cap_r, cap_nxt;
  logic [PAD-1:0]       nonempty_r, nonempty_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [LW-1:0]        leaf_r, leaf_nxt;
  logic [CHW-1:0]       chunk_r, chunk_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]     out_found_index_r, out_found_index_nxt;
  logic                 out_found_r, out_found_nxt;
  logic                 out_range_error_r, out_range_error_nxt;

  logic [CAP_W-1:0]     eff_cap;
  logic                 accept;
  hdb_pkg::req_t        in_req;

  logic                 ram_we;
  logic                 ram_re;
  logic [LW-1:0]        ram_waddr;
  logic [LW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_rdata;

  logic [PW-1:0]        div_prod;
  logic [PW-1:0]        div_q;
  logic [CAP_W-1:0]     set_bit_wide;
  logic [BW-1:0]        set_bit;
  logic [WORD_BITS-1:0] set_mask;

  logic [CB-1:0]        chunk_bits;
  logic [PEW-1:0]       chunk_pe;
  logic                 chunk_hit;
  logic                 chunk_last;
  logic [CHW+PEW-1:0]   scan_leaf_wide;
  logic [LW-1:0]        scan_leaf;

  logic [BW-1:0]        pop_bit;
  logic [CAP_W-1:0]     pop_item;
  logic [WORD_BITS-1:0] pop_rest;
  logic                 pop_beyond;

  assign busy      = (state_r != hdb_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign in_req    = hdb_pkg::req_t'(in_req_type);
  assign cfg_ready = 1'b1;

  // Clamp the capacity register into the usable range
  always_comb begin
    priority if (cap_r == '0) begin
      eff_cap = CAP_W'(1);
    end else if (cap_r > CAP_MAX) begin
      eff_cap = CAP_MAX;
    end else begin
      eff_cap = cap_r;
    end
  end

  // Split a set index into leaf and bit position
  assign div_prod     = PW'(idx_r) * PW'(RECIP);
  assign div_q        = div_prod >> DIV_SHIFT;
  assign set_bit_wide = CAP_W'(idx_r) - CAP_W'(leaf_r) * CAP_W'(WORD_BITS);
  assign set_bit      = set_bit_wide[BW-1:0];
  assign set_mask     = WORD_BITS'(1) << set_bit;

  // Select the current summary chunk and find its lowest non-empty leaf
  always_comb begin
    chunk_bits = '0;
    for (int c = 0; c < CHUNKS; c++) begin
      if (CHW'(c) == chunk_r) begin
        chunk_bits = nonempty_r[c*CB +: CB];
      end
    end
  end

  always_comb begin
    chunk_pe = '0;
    for (int i = CB - 1; i >= 0; i--) begin
      if (chunk_bits[i]) begin
        chunk_pe = PEW'(i);
      end
    end
  end

  assign chunk_hit      = |chunk_bits;
  assign chunk_last     = (chunk_r == CHW'(CHUNKS - 1));
  assign scan_leaf_wide = {chunk_r, chunk_pe};
  assign scan_leaf      = scan_leaf_wide[LW-1:0];

  // Lowest dirty bit of the leaf word just read
  always_comb begin
    pop_bit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (ram_rdata[i]) begin
        pop_bit = BW'(i);
      end
    end
  end

  assign pop_item   = CAP_W'(leaf_r) * CAP_W'(WORD_BITS) + CAP_W'(pop_bit);
  assign pop_rest   = ram_rdata & (ram_rdata - WORD_BITS'(1));
  assign pop_beyond = (pop_item >= eff_cap);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hdb_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_req)
            hdb_pkg::REQ_SET: begin
              if (CAP_W'(in_item_index) < eff_cap) begin
                state_nxt = hdb_pkg::ST_DIV;
              end
            end
            hdb_pkg::REQ_POP: begin
              state_nxt = hdb_pkg::ST_SCAN;
            end
            default: begin
              state_nxt = hdb_pkg::ST_IDLE;
            end
          endcase
        end
      end
      hdb_pkg::ST_DIV: begin
        state_nxt = hdb_pkg::ST_SET_RD;
      end
      hdb_pkg::ST_SET_RD: begin
        state_nxt = nonempty_r[leaf_r] ? hdb_pkg::ST_SET_WR : hdb_pkg::ST_IDLE;
      end
      hdb_pkg::ST_SET_WR: begin
        state_nxt = hdb_pkg::ST_IDLE;
      end
      hdb_pkg::ST_SCAN: begin
        priority if (chunk_hit) begin
          state_nxt = hdb_pkg::ST_POP_WR;
        end else if (chunk_last) begin
          state_nxt = hdb_pkg::ST_IDLE;
        end else begin
          state_nxt = hdb_pkg::ST_SCAN;
        end
      end
      hdb_pkg::ST_POP_WR: begin
        state_nxt = hdb_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = hdb_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath control, store updates and result
  always_comb begin
    ram_we              = 1'b0;
    ram_re              = 1'b0;
    ram_waddr           = leaf_r;
    ram_raddr           = leaf_r;
    ram_wdata           = '0;
    nonempty_nxt        = nonempty_r;
    idx_nxt             = idx_r;
    leaf_nxt            = leaf_r;
    chunk_nxt           = chunk_r;
    out_valid_nxt       = 1'b0;
    out_found_index_nxt = '0;
    out_found_nxt       = 1'b0;
    out_range_error_nxt = 1'b0;

    unique case (state_r)
      hdb_pkg::ST_IDLE: begin
        if (accept) begin
          idx_nxt   = in_item_index;
          chunk_nxt = '0;
          unique case (in_req)
            hdb_pkg::REQ_SET: begin
              // Flag an index at or beyond capacity and drop it
              if (CAP_W'(in_item_index) >= eff_cap) begin
                out_valid_nxt       = 1'b1;
                out_range_error_nxt = 1'b1;
              end
            end
            hdb_pkg::REQ_POP: begin
              out_valid_nxt = 1'b0;
            end
            hdb_pkg::REQ_CLEAR: begin
              nonempty_nxt  = '0;
              out_valid_nxt = 1'b1;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      hdb_pkg::ST_DIV: begin
        leaf_nxt = div_q[LW-1:0];
      end
      hdb_pkg::ST_SET_RD: begin
        // Empty leaf: write the single bit directly, else read it first
        if (nonempty_r[leaf_r]) begin
          ram_re = 1'b1;
        end else begin
          ram_we                 = 1'b1;
          ram_wdata              = set_mask;
          nonempty_nxt[leaf_r]   = 1'b1;
          out_valid_nxt          = 1'b1;
        end
      end
      hdb_pkg::ST_SET_WR: begin
        ram_we        = 1'b1;
        ram_wdata     = ram_rdata | set_mask;
        out_valid_nxt = 1'b1;
      end
      hdb_pkg::ST_SCAN: begin
        priority if (chunk_hit) begin
          leaf_nxt  = scan_leaf;
          ram_re    = 1'b1;
          ram_raddr = scan_leaf;
        end else if (chunk_last) begin
          out_valid_nxt = 1'b1;
        end else begin
          chunk_nxt = chunk_r + CHW'(1);
        end
      end
      hdb_pkg::ST_POP_WR: begin
        out_valid_nxt = 1'b1;
        // An item left at or above a shrunken capacity empties the whole store
        if (pop_beyond) begin
          nonempty_nxt = '0;
        end else begin
          ram_we               = 1'b1;
          ram_wdata            = pop_rest;
          nonempty_nxt[leaf_r] = |pop_rest;
          out_found_nxt        = 1'b1;
          out_found_index_nxt  = pop_item[IDX_W-1:0];
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // Capacity register write
  assign cap_nxt = cfg_valid ? cfg_capacity : cap_r;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hdb_pkg::ST_IDLE;
      cap_r       <= CAP_RESET;
      nonempty_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      nonempty_r  <= nonempty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r             <= idx_nxt;
    leaf_r            <= leaf_nxt;
    chunk_r           <= chunk_nxt;
    out_found_index_r <= out_found_index_nxt;
    out_found_r       <= out_found_nxt;
    out_range_error_r <= out_range_error_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_found_index = out_found_index_r;
  assign out_found       = out_found_r;
  assign out_range_error = out_range_error_r;

  // Leaf word storage
  hdb_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (LEAF_COUNT)
  ) u_leaf_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
